// ===== src/ready_queue_skip_sleeping_top_macros.svh =====
// assertion macros for the ready queue block
`ifndef READY_QUEUE_SKIP_SLEEPING_TOP_MACROS_SVH
`define READY_QUEUE_SKIP_SLEEPING_TOP_MACROS_SVH

// clocked assertion with reset disable
`define RQSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define RQSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/rqss_pkg.sv =====
// shared types and codes for the ready queue block
package rqss_pkg;

    typedef enum logic [2:0] {
        KIND_ADD  = 3'd0,
        KIND_POLL = 3'd1,
        KIND_PEEK = 3'd2,
        KIND_FIND = 3'd3,
        KIND_SET  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_SH_RD,
        S_SH_WR,
        S_DONE
    } state_t;

    localparam int PID_W = 16;
    localparam int SLOT_W = 4;
    localparam int OCC_W = 5;

endpackage

// ===== src/rqss_ram.sv =====
// generic single-port-write ram with registered read
module rqss_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/ready_queue_skip_sleeping_top.sv =====
// ready queue with skip of sleeping entries, top level
//  channel | signals                                   | dir
//  in      | in_valid in_ready kind proc_id asleep_in  | in
//          | skip_asleep slot                          |
//  out     | out_valid out_ready status proc_id_out    | out
//          | asleep_out occupancy                      |
// add writes at the tail; peek reads the given slot; find, set and poll
// scan in order through read and check states, poll then moves each entry
// behind the removed one forward, all bound by the single entry ram port
// reset clears the count and the handshake; no clearing pass is needed
// a result waits in the output register while the next item is accepted
module ready_queue_skip_sleeping_top #(
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           kind,
    input  logic [15:0]          proc_id,
    input  logic                 asleep_in,
    input  logic                 skip_asleep,
    input  logic [3:0]           slot,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [15:0]          proc_id_out,
    output logic                 asleep_out,
    output logic [4:0]           occupancy
);
    import rqss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;

    state_t              state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       count_reg, count_next;
    kind_t               kind_reg, kind_next;
    logic [PID_W-1:0]    pid_reg, pid_next;
    logic                asleep_reg, asleep_next;
    logic                skip_reg, skip_next;
    status_t             res_status_reg, res_status_next;
    logic [PID_W-1:0]    res_pid_reg, res_pid_next;
    logic                res_asleep_reg, res_asleep_next;
    logic                out_valid_reg, out_valid_next;
    logic [1:0]          status_reg, status_next;
    logic [PID_W-1:0]    pid_out_reg, pid_out_next;
    logic                asleep_out_reg, asleep_out_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [PID_W:0]      mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [PID_W:0]      mem_rdata;
    logic                rd_asleep;
    logic [PID_W-1:0]    rd_pid;
    logic                hit;
    logic                last;

    rqss_ram #(
        .WIDTH (PID_W + 1),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_asleep = mem_rdata[PID_W];
    assign rd_pid = mem_rdata[PID_W-1:0];
    assign last = ((CW'(idx_reg) + CW'(1)) >= count_reg);

    always_comb
    begin
        case (kind_reg)
            KIND_POLL: hit = !skip_reg || !rd_asleep;
            KIND_PEEK: hit = 1'b1;
            default:   hit = (rd_pid == pid_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        kind_reg <= kind_next;
        pid_reg <= pid_next;
        asleep_reg <= asleep_next;
        skip_reg <= skip_next;
        res_status_reg <= res_status_next;
        res_pid_reg <= res_pid_next;
        res_asleep_reg <= res_asleep_next;
        status_reg <= status_next;
        pid_out_reg <= pid_out_next;
        asleep_out_reg <= asleep_out_next;
        occ_reg <= occ_next;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        count_next = count_reg;
        kind_next = kind_reg;
        pid_next = pid_reg;
        asleep_next = asleep_reg;
        skip_next = skip_reg;
        res_status_next = res_status_reg;
        res_pid_next = res_pid_reg;
        res_asleep_next = res_asleep_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next = status_reg;
        pid_out_next = pid_out_reg;
        asleep_out_next = asleep_out_reg;
        occ_next = occ_reg;
        mem_we = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {asleep_reg, pid_reg};
        mem_raddr = idx_reg;
        in_ready = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next = kind_t'(kind);
                    pid_next = proc_id;
                    asleep_next = asleep_in;
                    skip_next = skip_asleep;
                    res_status_next = ST_NONE;
                    res_pid_next = '0;
                    res_asleep_next = 1'b0;
                    idx_next = '0;
                    state_next = S_DONE;
                    unique case (kind) inside
                        KIND_ADD:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                mem_waddr = AW'(count_reg);
                                mem_wdata = {asleep_in, proc_id};
                                count_next = count_reg + CW'(1);
                                res_status_next = ST_OK;
                            end
                        end
                        KIND_POLL, KIND_FIND, KIND_SET:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_RD;
                            end
                        end
                        KIND_PEEK:
                        begin
                            if (XW'(slot) < XW'(count_reg))
                            begin
                                idx_next = AW'(slot);
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_NONE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (hit)
                begin
                    res_status_next = ST_OK;
                    res_pid_next = rd_pid;
                    res_asleep_next = rd_asleep;
                    state_next = S_DONE;
                    if (kind_reg == KIND_SET)
                    begin
                        mem_we = 1'b1;
                        mem_wdata = {asleep_reg, rd_pid};
                        res_asleep_next = asleep_reg;
                    end
                    if (kind_reg == KIND_POLL)
                    begin
                        state_next = S_SH_RD;
                    end
                end
                else if (last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                    state_next = S_RD;
                end
            end
            S_SH_RD:
            begin
                if (last)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr = idx_reg + AW'(1);
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                mem_we = 1'b1;
                mem_wdata = mem_rdata;
                idx_next = idx_reg + AW'(1);
                state_next = S_SH_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next = res_status_reg;
                    pid_out_next = res_pid_reg;
                    asleep_out_next = res_asleep_reg;
                    occ_next = OCC_W'(count_reg);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign proc_id_out = pid_out_reg;
    assign asleep_out = asleep_out_reg;
    assign occupancy = occ_reg;

endmodule

// ===== src/rqss_chk.sv =====
// port checker for the ready queue block and its bind
`include "ready_queue_skip_sleeping_top_macros.svh"

module rqss_chk #(
    parameter int DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  kind,
    input logic [15:0] proc_id,
    input logic        asleep_in,
    input logic        skip_asleep,
    input logic [3:0]  slot,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [15:0] proc_id_out,
    input logic        asleep_out,
    input logic [4:0]  occupancy
);
    import rqss_pkg::*;

    `RQSS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(proc_id_out) && $stable(occupancy), "result changed while stalled")
    `RQSS_ASSERT(a_zero_on_fail, clk, rst_n, out_valid && status != ST_OK |-> proc_id_out == 16'd0 && !asleep_out, "failed result carries data")
    `RQSS_ASSERT(a_one_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready, "item taken while busy")
    `RQSS_ASSERT(a_status_code, clk, rst_n, out_valid |-> status == ST_OK || status == ST_FULL || status == ST_NONE, "bad status code")
    `RQSS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !out_valid, "result shown in reset")

endmodule

bind ready_queue_skip_sleeping_top rqss_chk #(.DEPTH(DEPTH)) u_rqss_chk (.*);
